[rtl/core/asl_pkg.sv]
// ----------------------------------------------------------------------------
// asl_pkg: shared types and constants for the address-to-symbol lookup
// Table geometry, field widths, mode and status codes, the entry record and
// the per-cell control group.
// ----------------------------------------------------------------------------
`default_nettype none

package asl_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int ADDR_W      = 64;
	localparam int REF_W       = 16;
	localparam int MODE_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int USED_W      = 7;
	localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

	// Selection tree: cells are OR-reduced in groups, then across groups.
	localparam int GROUP_SIZE  = 8;
	localparam int N_GROUPS    = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int PAD_DEPTH   = N_GROUPS * GROUP_SIZE;

	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd3;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] length;
		logic [REF_W-1:0]  ref_num;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic valid;
		logic ins_en;
	} cell_ctl_t;

endpackage

`default_nettype wire

[rtl/core/asl_req_if.sv]
// ----------------------------------------------------------------------------
// asl_req_if: request channel of the symbol lookup
// Valid/ready handshake carrying one mode item with its insert and lookup fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface asl_req_if;
	import asl_pkg::*;

	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [ADDR_W-1:0]   sym_start;
	logic [ADDR_W-1:0]   sym_length;
	logic [REF_W-1:0]    sym_ref;
	logic [ADDR_W-1:0]   lookup_address;

	modport source (
		output valid, mode, sym_start, sym_length, sym_ref, lookup_address,
		input  ready
	);

	modport sink (
		input  valid, mode, sym_start, sym_length, sym_ref, lookup_address,
		output ready
	);

endinterface

`default_nettype wire

[rtl/core/asl_rsp_if.sv]
// ----------------------------------------------------------------------------
// asl_rsp_if: response channel of the symbol lookup
// Valid/ready handshake carrying one result item per request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface asl_rsp_if;
	import asl_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [REF_W-1:0]    hit_ref;
	logic [ADDR_W-1:0]   hit_offset;
	logic [USED_W-1:0]   entries_used;

	modport source (
		output valid, status, hit_ref, hit_offset, entries_used,
		input  ready
	);

	modport sink (
		input  valid, status, hit_ref, hit_offset, entries_used,
		output ready
	);

endinterface

`default_nettype wire

[rtl/core/address_to_symbol_lookup.sv]
// Latency: clear or insert result is valid 2 cycles after the request item is
// accepted, a lookup result 4 cycles after; output back-pressure adds to both.
// Throughput: one item every 3 (clear/insert) or 5 (lookup) cycles, set by the
// two-level registered selection tree across the cell chain and the final
// subtract/compare stage. Reset empties the table (count zero); entry contents
// are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// address_to_symbol_lookup: sorted interval table with address resolution
// A chain of cells keeps symbols ordered by start ascending, then length
// descending. Inserts shift the chain in one cycle; lookups pick the last
// entry at or below the address and check that the address falls inside it.
// ----------------------------------------------------------------------------
`default_nettype none

module address_to_symbol_lookup (
	input  logic      clk,
	input  logic      arst_n,
	asl_req_if.sink   req,
	asl_rsp_if.source rsp
);
	import asl_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REDUCE,
		ST_RESOLVE,
		ST_DONE
	} state_t;

	state_t state_q;

	// Accepted item, held for the whole operation.
	logic [MODE_W-1:0] item_mode_q;
	logic [ADDR_W-1:0] item_start_q;
	logic [ADDR_W-1:0] item_length_q;
	logic [REF_W-1:0]  item_ref_q;
	logic [ADDR_W-1:0] item_addr_q;

	logic [COUNT_W-1:0] count_q;

	// Result waiting to be moved into the output register.
	logic [STATUS_W-1:0] res_status_q;
	logic [REF_W-1:0]    res_ref_q;
	logic [ADDR_W-1:0]   res_offset_q;

	// Output register.
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [REF_W-1:0]    out_ref_q;
	logic [ADDR_W-1:0]   out_offset_q;
	logic [USED_W-1:0]   out_used_q;

	logic accept;
	logic full;
	logic ins_en;
	logic can_load;
	logic load_out;
	entry_t new_ent;

	assign accept   = req.valid && req.ready;
	assign full     = (count_q == COUNT_W'(TABLE_DEPTH));
	assign can_load = !out_valid_q || rsp.ready;
	assign load_out = (state_q == ST_DONE) && can_load;

	// Drop inserts with start zero and inserts into a full table.
	assign ins_en = (state_q == ST_EXEC) && (item_mode_q == MODE_INSERT) &&
		(item_start_q != '0) && !full;

	assign new_ent.start   = item_start_q;
	assign new_ent.length  = item_length_q;
	assign new_ent.ref_num = item_ref_q;

	// ------------------------------------------------------------------
	// Cell chain
	// ------------------------------------------------------------------
	entry_t cell_ent    [TABLE_DEPTH];
	logic   cell_before [TABLE_DEPTH];
	logic   cell_match  [TABLE_DEPTH];
	logic   sel_pad     [PAD_DEPTH];
	logic [ENTRY_W-1:0] ent_pad [PAD_DEPTH];

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		cell_ctl_t ctl;
		entry_t    prev_ent;
		logic      prev_before;
		logic      next_match;

		assign ctl.valid  = (count_q > COUNT_W'(i));
		assign ctl.ins_en = ins_en;

		if (i == 0) begin : g_head
			assign prev_ent    = '0;
			assign prev_before = 1'b1;
		end else begin : g_body
			assign prev_ent    = cell_ent[i-1];
			assign prev_before = cell_before[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign next_match = 1'b0;
		end else begin : g_mid
			assign next_match = cell_match[i+1];
		end

		asl_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.new_ent     (new_ent),
			.prev_ent    (prev_ent),
			.prev_before (prev_before),
			.addr        (item_addr_q),
			.ent         (cell_ent[i]),
			.ahead       (cell_before[i]),
			.match       (cell_match[i])
		);

		// Matches form a prefix of the sorted chain: the last one is the
		// cell whose right neighbor does not match.
		assign sel_pad[i] = cell_match[i] && !next_match;
		assign ent_pad[i] = cell_ent[i];
	end

	for (genvar i = TABLE_DEPTH; i < PAD_DEPTH; i++) begin : g_pad
		assign sel_pad[i] = 1'b0;
		assign ent_pad[i] = '0;
	end

	// ------------------------------------------------------------------
	// Selection tree: group OR, registered; then OR across groups
	// ------------------------------------------------------------------
	logic [ENTRY_W-1:0] grp_data_s1 [N_GROUPS];
	logic               grp_hit_s1  [N_GROUPS];
	logic [ENTRY_W-1:0] sel_data_s2;
	logic               sel_hit_s2;

	for (genvar g = 0; g < N_GROUPS; g++) begin : g_grp
		logic [ENTRY_W-1:0] acc_data;
		logic               acc_hit;

		always_comb begin
			acc_data = '0;
			acc_hit  = 1'b0;
			for (int j = 0; j < GROUP_SIZE; j++) begin
				if (sel_pad[g*GROUP_SIZE + j]) begin
					acc_data = acc_data | ent_pad[g*GROUP_SIZE + j];
					acc_hit  = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			grp_data_s1[g] <= acc_data;
			grp_hit_s1[g]  <= acc_hit;
		end
	end

	logic [ENTRY_W-1:0] top_data;
	logic               top_hit;

	always_comb begin
		top_data = '0;
		top_hit  = 1'b0;
		for (int g = 0; g < N_GROUPS; g++) begin
			top_data = top_data | grp_data_s1[g];
			top_hit  = top_hit | grp_hit_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		sel_data_s2 <= top_data;
		sel_hit_s2  <= top_hit;
	end

	// ------------------------------------------------------------------
	// Range check on the selected entry
	// ------------------------------------------------------------------
	entry_t            best;
	logic [ADDR_W-1:0] delta;
	logic              in_range;

	assign best  = entry_t'(sel_data_s2);
	assign delta = item_addr_q - best.start;

	// Unsized entry covers only its exact start.
	always_comb begin
		if (best.length == '0) begin
			in_range = (delta == '0);
		end else begin
			in_range = (delta < best.length);
		end
	end

	// ------------------------------------------------------------------
	// Item registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			item_mode_q   <= req.mode;
			item_start_q  <= req.sym_start;
			item_length_q <= req.sym_length;
			item_ref_q    <= req.sym_ref;
			item_addr_q   <= req.lookup_address;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer: state, count and output valid
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise valid on a new result, drop it once the held one is taken.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (item_mode_q == MODE_LOOKUP) begin
						state_q <= ST_REDUCE;
					end else begin
						state_q <= ST_DONE;
					end
					if (item_mode_q == MODE_CLEAR) begin
						count_q <= '0;
					end else if (ins_en) begin
						count_q <= count_q + COUNT_W'(1);
					end
				end
				ST_REDUCE: begin
					state_q <= ST_RESOLVE;
				end
				ST_RESOLVE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result registers: fill from the mode decode or from the range check.
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			res_ref_q    <= '0;
			res_offset_q <= '0;
			case (item_mode_q)
				MODE_INSERT: begin
					if (item_start_q == '0) begin
						res_status_q <= STATUS_ZERO;
					end else if (full) begin
						res_status_q <= STATUS_FULL;
					end else begin
						res_status_q <= STATUS_OK;
					end
				end
				default: begin
					res_status_q <= STATUS_OK;
				end
			endcase
		end else if (state_q == ST_RESOLVE) begin
			if (sel_hit_s2 && in_range) begin
				res_status_q <= STATUS_OK;
				res_ref_q    <= best.ref_num;
				res_offset_q <= delta;
			end else begin
				res_status_q <= STATUS_MISS;
				res_ref_q    <= '0;
				res_offset_q <= '0;
			end
		end
	end

	// Count after the item, masked to the output width.
	logic [COUNT_W+USED_W-1:0] used_ext;
	assign used_ext = {{USED_W{1'b0}}, count_q};

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= res_status_q;
			out_ref_q    <= res_ref_q;
			out_offset_q <= res_offset_q;
			out_used_q   <= used_ext[USED_W-1:0];
		end
	end

	assign req.ready        = (state_q == ST_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.hit_ref      = out_ref_q;
	assign rsp.hit_offset   = out_offset_q;
	assign rsp.entries_used = out_used_q;

endmodule

`default_nettype wire

[rtl/core/asl_cell.sv]
// ----------------------------------------------------------------------------
// asl_cell: one slot of the sorted symbol chain
// Holds one entry, compares it with the incoming symbol and the lookup address,
// and on insert either holds, takes the new entry, or takes its left neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module asl_cell (
	input  logic                      clk,
	input  asl_pkg::cell_ctl_t        ctl,
	input  asl_pkg::entry_t           new_ent,
	input  asl_pkg::entry_t           prev_ent,
	input  logic                      prev_before,
	input  logic [asl_pkg::ADDR_W-1:0] addr,
	output asl_pkg::entry_t           ent,
	output logic                      ahead,
	output logic                      match
);
	import asl_pkg::*;

	entry_t ent_q;

	// Entry sorts at or before the new symbol: lower start, or same start and
	// length not smaller (equal ties stay ahead of the newcomer).
	always_comb begin
		if (ent_q.start != new_ent.start) begin
			ahead = ctl.valid && (ent_q.start < new_ent.start);
		end else begin
			ahead = ctl.valid && (ent_q.length >= new_ent.length);
		end
	end

	assign match = ctl.valid && (ent_q.start <= addr);
	assign ent   = ent_q;

	// Insert point takes the new entry, everything behind it shifts right.
	always_ff @(posedge clk) begin
		if (ctl.ins_en && !ahead) begin
			ent_q <= prev_before ? new_ent : prev_ent;
		end
	end

endmodule

`default_nettype wire

[verif/symbol_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_table_checker: result predictor and scoreboard for the symbol lookup
// Watches both channels, keeps its own sorted symbol table, and compares each
// result item against the oldest predicted one.
// ----------------------------------------------------------------------------

module symbol_table_checker (
	input  logic clk,
	input  logic arst_n,
	asl_req_if   req,
	asl_rsp_if   rsp,
	output int   mismatches,
	output int   outstanding
);
	import asl_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [REF_W-1:0]    hit_ref;
		logic [ADDR_W-1:0]   hit_offset;
		logic [USED_W-1:0]   entries_used;
	} symbol_result_t;

	logic [ADDR_W-1:0] tbl_start  [TABLE_DEPTH];
	logic [ADDR_W-1:0] tbl_length [TABLE_DEPTH];
	logic [REF_W-1:0]  tbl_ref    [TABLE_DEPTH];
	int                table_fill;

	symbol_result_t    pending_results[$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
		table_fill  = 0;
	end

	// Apply one request to the local table and return the result it causes.
	function automatic symbol_result_t resolve_item(
		input logic [MODE_W-1:0] mode,
		input logic [ADDR_W-1:0] start,
		input logic [ADDR_W-1:0] length,
		input logic [REF_W-1:0]  ref_num,
		input logic [ADDR_W-1:0] addr
	);
		symbol_result_t    res;
		int                pos;
		int                best;
		bit                found;
		logic [ADDR_W-1:0] delta;
		res        = '0;
		res.status = STATUS_OK;
		case (mode)
			MODE_CLEAR: begin
				table_fill = 0;
			end
			MODE_INSERT: begin
				if (start == '0) begin
					res.status = STATUS_ZERO;
				end else if (table_fill >= TABLE_DEPTH) begin
					res.status = STATUS_FULL;
				end else begin
					// Go past lower starts and, on equal starts, longer or equal lengths.
					pos = 0;
					while (pos < table_fill && (tbl_start[pos] < start ||
							(tbl_start[pos] == start && tbl_length[pos] >= length)))
						pos++;
					for (int k = table_fill; k > pos; k--) begin
						tbl_start[k]  = tbl_start[k-1];
						tbl_length[k] = tbl_length[k-1];
						tbl_ref[k]    = tbl_ref[k-1];
					end
					tbl_start[pos]  = start;
					tbl_length[pos] = length;
					tbl_ref[pos]    = ref_num;
					table_fill++;
				end
			end
			MODE_LOOKUP: begin
				res.status = STATUS_MISS;
				found      = 1'b0;
				best       = 0;
				if (addr != '0) begin
					for (int i = 0; i < table_fill; i++) begin
						if (tbl_start[i] <= addr) begin
							best  = i;
							found = 1'b1;
						end
					end
					if (found) begin
						delta = addr - tbl_start[best];
						if ((tbl_length[best] == '0) ? (delta == '0) : (delta < tbl_length[best])) begin
							res.status     = STATUS_OK;
							res.hit_ref    = tbl_ref[best];
							res.hit_offset = delta;
						end
					end
				end
			end
			default: begin
				// unused mode: leave the table alone
			end
		endcase
		res.entries_used = USED_W'(table_fill);
		return res;
	endfunction

	task automatic report_failure(input string what, input symbol_result_t want,
			input symbol_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s: want status=%0d ref=%h offset=%h used=%0d, got status=%0d ref=%h offset=%h used=%0d",
				$time, what, want.status, want.hit_ref, want.hit_offset, want.entries_used,
				got.status, got.hit_ref, got.hit_offset, got.entries_used);
	endtask

	always @(posedge clk) begin : watch
		symbol_result_t got;
		symbol_result_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.status, rsp.hit_ref, rsp.hit_offset, rsp.entries_used};
				if (pending_results.size() == 0) begin
					report_failure("result with nothing expected", '0, got);
				end else begin
					want = pending_results.pop_front();
					if (got !== want)
						report_failure("result mismatch", want, got);
				end
			end
			if (req.valid && req.ready)
				pending_results.push_back(resolve_item(req.mode, req.sym_start, req.sym_length,
					req.sym_ref, req.lookup_address));
			outstanding = pending_results.size();
		end
	end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the address-to-symbol lookup
// Runs a directed pass over the table's corner cases, then random sequences
// of clears, inserts and targeted lookups with random idling on both sides.
// ----------------------------------------------------------------------------

module tb;
	import asl_pkg::*;

	// The fourth mode value is unused by the block and must be ignored.
	localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
	localparam logic [ADDR_W-1:0] ADDR_MAX     = '1;
	localparam int                RANDOM_ITEMS = 1030;
	localparam int                CYCLE_LIMIT  = 600000;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] length;
		logic [REF_W-1:0]  ref_num;
		logic [ADDR_W-1:0] addr;
	} sym_req_t;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   cycles = 0;
	int   items_sent = 0;
	int   n_clear = 0, n_insert = 0, n_lookup = 0, n_ignored = 0, n_drains = 0;
	int   stall_left = 0;
	bit   steady = 1'b0;

	// Symbols the table should hold right now; used to aim lookups and to repeat starts.
	logic [ADDR_W-1:0] held_start[$];
	logic [ADDR_W-1:0] held_length[$];
	logic [ADDR_W-1:0] region;

	asl_req_if req ();
	asl_rsp_if rsp ();

	address_to_symbol_lookup dut (
		.clk,
		.arst_n,
		.req (req),
		.rsp (rsp)
	);

	symbol_table_checker chk (
		.clk,
		.arst_n,
		.req         (req),
		.rsp         (rsp),
		.mismatches,
		.outstanding
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stop a hung run at CYCLE_LIMIT.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [ADDR_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly short gaps, a few long ones; none at all in steady stretches.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Cluster starts inside a region so that lookups and ties meet often.
	function automatic logic [ADDR_W-1:0] rand_start();
		case ($urandom_range(0, 19))
			0:       return '0;
			1, 2:    return rand64();
			3:       return ADDR_W'($urandom_range(1, 16));
			4:       return ADDR_MAX - ADDR_W'($urandom_range(0, 255));
			5, 6:    return (held_start.size() > 0) ?
				held_start[$urandom_range(0, held_start.size() - 1)] : rand64();
			default: return region + ADDR_W'($urandom_range(0, 63) << 5);
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] rand_length();
		case ($urandom_range(0, 9))
			0, 1:    return '0;
			2, 3:    return ADDR_W'($urandom_range(1, 64));
			7:       return rand64();
			8:       return ADDR_MAX;
			9:       return ADDR_W'(1) << $urandom_range(0, 63);
			default: return ADDR_W'($urandom_range(1, 4096));
		endcase
	endfunction

	// Aim at the edges and inside of a symbol the table should hold.
	function automatic logic [ADDR_W-1:0] near_symbol();
		int                k;
		logic [ADDR_W-1:0] s;
		logic [ADDR_W-1:0] l;
		if (held_start.size() == 0)
			return rand64();
		k = $urandom_range(0, held_start.size() - 1);
		s = held_start[k];
		l = held_length[k];
		case ($urandom_range(0, 5))
			0:       return s;
			1:       return s + l - 1;
			2:       return s + l;
			3:       return s - 1;
			4:       return (l == '0) ? s : s + (rand64() % l);
			default: return s + ADDR_W'($urandom_range(0, 63));
		endcase
	endfunction

	function automatic sym_req_t make_item(input logic [MODE_W-1:0] mode,
			input logic [ADDR_W-1:0] start, input logic [ADDR_W-1:0] length,
			input logic [REF_W-1:0] ref_num, input logic [ADDR_W-1:0] addr);
		sym_req_t it;
		it.mode    = mode;
		it.start   = start;
		it.length  = length;
		it.ref_num = ref_num;
		it.addr    = addr;
		return it;
	endfunction

	// Present one item after a random gap and hold it until accepted.
	task automatic send(input sym_req_t it);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid          <= 1'b1;
		req.mode           <= it.mode;
		req.sym_start      <= it.start;
		req.sym_length     <= it.length;
		req.sym_ref        <= it.ref_num;
		req.lookup_address <= it.addr;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		// Track what the table should now hold, for aiming later lookups.
		case (it.mode)
			MODE_CLEAR: begin
				n_clear++;
				held_start.delete();
				held_length.delete();
			end
			MODE_INSERT: begin
				n_insert++;
				if (it.start != '0 && held_start.size() < TABLE_DEPTH) begin
					held_start.push_back(it.start);
					held_length.push_back(it.length);
				end
			end
			MODE_LOOKUP: n_lookup++;
			default:     n_ignored++;
		endcase
		items_sent++;
	endtask

	task automatic clear_table();
		send(make_item(MODE_CLEAR, rand64(), rand64(), REF_W'($urandom), rand64()));
	endtask

	task automatic insert_sym(input logic [ADDR_W-1:0] start, input logic [ADDR_W-1:0] length,
			input logic [REF_W-1:0] ref_num);
		send(make_item(MODE_INSERT, start, length, ref_num, rand64()));
	endtask

	task automatic lookup_addr(input logic [ADDR_W-1:0] addr);
		send(make_item(MODE_LOOKUP, rand64(), rand64(), REF_W'($urandom), addr));
	endtask

	// Hold the sender off until every predicted result is back.
	task automatic drain_results();
		@(negedge clk);
		req.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		n_drains++;
	endtask

	// Result side: stay ready, now and then stall for a random stretch.
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	initial begin : stimulus
		int k;
		int n_ins;
		int n_look;

		arst_n             = 1'b0;
		req.valid          = 1'b0;
		req.mode           = MODE_CLEAR;
		req.sym_start      = '0;
		req.sym_length     = '0;
		req.sym_ref        = '0;
		req.lookup_address = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: an empty table misses everything, address zero included.
		lookup_addr('0);
		lookup_addr(64'h5);
		// Drop a zero start; then stack equal starts to check the ordering:
		// longer first, and equal pairs in arrival order.
		insert_sym('0, 64'h40, 16'h1111);
		insert_sym(64'h1000, 64'h100, 16'h0001);
		insert_sym(64'h1000, 64'h200, 16'h0002);
		insert_sym(64'h1000, 64'h100, 16'h0003);
		insert_sym(64'h2000, '0, 16'h0004);
		insert_sym(ADDR_MAX, ADDR_MAX, 16'hFFFF);
		lookup_addr(64'h0FFF);        // below the first start
		lookup_addr(64'h1000);        // last of the tied pair wins
		lookup_addr(64'h10FF);
		lookup_addr(64'h1100);        // past the chosen entry, though a longer one covers it
		lookup_addr(64'h2000);        // unsized symbol at its exact start
		lookup_addr(64'h2001);        // unsized symbol one past its start
		lookup_addr('0);              // address zero misses even with a full-range entry
		lookup_addr(ADDR_MAX);
		lookup_addr(ADDR_MAX - 1);
		send(make_item(MODE_IGNORED, ADDR_MAX, ADDR_MAX, 16'hFFFF, ADDR_MAX));
		send(make_item(MODE_IGNORED, '0, '0, '0, '0));
		lookup_addr(64'h1000);
		clear_table();
		lookup_addr(64'h1000);
		insert_sym(64'h1, ADDR_MAX, '0);
		lookup_addr(ADDR_MAX);        // largest possible offset
		drain_results();

		// Offer more inserts than the table's depth; once it is full, later ones are dropped.
		region = rand64() & ~64'hFFFF;
		clear_table();
		repeat (TABLE_DEPTH + 3) insert_sym(rand_start(), rand_length(), REF_W'($urandom));
		repeat (20) lookup_addr(near_symbol());
		drain_results();

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) < 8) begin
				// Well-formed sequence: optional clear, inserts, then aimed lookups.
				if ($urandom_range(0, 1))
					clear_table();
				region = rand64() & ~64'hFFFF;
				n_ins  = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) :
					$urandom_range(1, 20);
				repeat (n_ins) begin
					if (held_start.size() > 0 && $urandom_range(0, 9) == 0) begin
						k = $urandom_range(0, held_start.size() - 1);
						insert_sym(held_start[k], held_length[k], REF_W'($urandom));
					end else begin
						insert_sym(rand_start(), rand_length(), REF_W'($urandom));
					end
				end
				n_look = $urandom_range(4, 24);
				repeat (n_look)
					lookup_addr(($urandom_range(0, 4) == 0) ? rand64() : near_symbol());
			end else begin
				// Noise: any mode with loosely related fields.
				repeat ($urandom_range(1, 8))
					send(make_item(MODE_W'($urandom_range(0, 3)), rand_start(), rand_length(),
						REF_W'($urandom), ($urandom_range(0, 3) == 0) ? '0 : rand64()));
			end
			if ($urandom_range(0, 9) == 0)
				drain_results();
		end

		steady = 1'b0;
		drain_results();
		repeat (12) @(posedge clk);

		$display("Covered %0d clears, %0d inserts, %0d lookups, %0d ignored items in %0d cycles.",
			n_clear, n_insert, n_lookup, n_ignored, cycles);
		$display("Sender held off %0d times for a full drain; %0d result mismatches counted.",
			n_drains, mismatches);
		if (mismatches == 0 && outstanding == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/asl_pkg.sv
rtl/core/asl_req_if.sv
rtl/core/asl_rsp_if.sv
rtl/core/asl_cell.sv
rtl/core/address_to_symbol_lookup.sv
verif/symbol_table_checker.sv
verif/tb.sv
